// ===== sv/s60r_pkg.sv =====
// Package: shared constants and the group transaction type for the 60-bit sector repacker.
package s60r_pkg;

  // Field and group geometry
  localparam int BYTE_W        = 8;
  localparam int GROUP_BYTES   = 8;
  localparam int GROUP_W       = BYTE_W * GROUP_BYTES;
  localparam int WORD_BITS     = 60;
  localparam int NIBBLE_W      = 4;
  localparam int HEADER_BYTES  = 3;
  localparam int SHORT_RUN     = GROUP_BYTES - 1;

  // Defaults for the top-level parameters
  localparam int DEF_GROUPS_PER_SECTOR = 64;
  localparam int DEF_OUT_SECTOR_BYTES  = 512;

  // Completed group, handed from the gather stage to the serializer
  typedef struct packed {
    logic [GROUP_W-1:0] data;        // output bits, top aligned
    logic               eight_bytes; // 8 data bytes, else 7
    logic               header;      // first group of a sector
    logic               sector_end;  // last group of a sector
  } grp_t;

endpackage

// ===== sv/s60r_in_if.sv =====
// Interface: input byte channel (valid/ready).
interface s60r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport mon    (input valid, input in_byte, input ready);
endinterface

// ===== sv/s60r_out_if.sv =====
// Interface: packed output byte channel (valid/ready).
interface s60r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       sector_done;

  modport source (output valid, output out_byte, output run_last, output sector_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input sector_done,
                  output ready);
  modport mon    (input valid, input out_byte, input run_last, input sector_done,
                  input ready);
endinterface

// ===== sv/s60r_gather.sv =====
// Gather stage: collects eight bytes into a group, drops the top nibble, applies the carry.
module s60r_gather import s60r_pkg::*; #(
  parameter int GROUPS_PER_SECTOR = DEF_GROUPS_PER_SECTOR
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  s60r_in_if.sink     image,
  output grp_t        grp,
  output logic        grp_valid,
  input  logic        grp_ready
);

  localparam int GCW = $clog2(GROUPS_PER_SECTOR);

  logic                reversed_order;
  logic [2:0]          pos;
  logic [BYTE_W-1:0]   held [SHORT_RUN];
  logic [GCW-1:0]      group_count;
  logic [NIBBLE_W-1:0] carry_nibble;
  logic                carry_held;

  logic                accept;
  logic                completes;
  logic [GROUP_W-1:0]  full;
  logic [WORD_BITS-1:0] word;
  logic                sect_end;
  grp_t                grp_next;

  // Input may proceed unless it completes a group while one is still pending
  assign image.ready = (pos != 3'(SHORT_RUN)) || !grp_valid || grp_ready;
  assign accept      = image.valid && image.ready;
  assign completes   = accept && (pos == 3'(SHORT_RUN));

  // Byte order of the whole group follows the register at the eighth byte
  always_comb begin
    full = '0;
    if (reversed_order) begin
      for (int i = 0; i < SHORT_RUN; i++) full[BYTE_W*i +: BYTE_W] = held[i];
      full[GROUP_W-1 -: BYTE_W] = image.in_byte;
    end else begin
      for (int i = 0; i < SHORT_RUN; i++)
        full[BYTE_W*(SHORT_RUN-i) +: BYTE_W] = held[i];
      full[BYTE_W-1:0] = image.in_byte;
    end
  end

  assign word     = full[WORD_BITS-1:0];
  assign sect_end = (group_count == GCW'(GROUPS_PER_SECTOR - 1));

  // Group transaction: carry joins on top; otherwise the low nibble goes last
  always_comb begin
    grp_next.data        = carry_held ? {carry_nibble, word} : {word, NIBBLE_W'(0)};
    grp_next.eight_bytes = carry_held || sect_end;
    grp_next.header      = (group_count == '0);
    grp_next.sector_end  = sect_end;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      reversed_order <= 1'b1;
      pos            <= '0;
      group_count    <= '0;
      carry_held     <= 1'b0;
      grp_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) reversed_order <= cfg_wr_data;
      if (completes) begin
        pos       <= '0;
        grp_valid <= 1'b1;
        if (sect_end) begin
          group_count <= '0;
          carry_held  <= 1'b0;
        end else begin
          group_count <= group_count + GCW'(1);
          carry_held  <= !carry_held;
        end
      end else begin
        if (accept) pos <= pos + 3'd1;
        if (grp_ready) grp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept && !completes) held[pos] <= image.in_byte;
    if (completes) begin
      grp          <= grp_next;
      carry_nibble <= word[NIBBLE_W-1:0];
    end
  end

endmodule

// ===== sv/s60r_serial.sv =====
// Serializer: emits header, data and padding bytes of one group into the output register.
module s60r_serial import s60r_pkg::*; #(
  parameter int GROUPS_PER_SECTOR = DEF_GROUPS_PER_SECTOR,
  parameter int OUT_SECTOR_BYTES  = DEF_OUT_SECTOR_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  grp_t        grp,
  input  logic        grp_valid,
  output logic        grp_ready,
  s60r_out_if.source  sector
);

  localparam int USED    = HEADER_BYTES + (GROUPS_PER_SECTOR * WORD_BITS + 7) / 8;
  localparam int PAD     = (OUT_SECTOR_BYTES > USED) ? OUT_SECTOR_BYTES - USED : 0;
  localparam int MAX_RUN = HEADER_BYTES + GROUP_BYTES + PAD;
  localparam int CW      = $clog2(MAX_RUN);

  logic               busy;
  logic [GROUP_W-1:0] data;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      hdr_end;
  logic [CW-1:0]      data_end;
  logic [CW-1:0]      last_idx;
  logic               sect_end;

  logic               o_valid;
  logic [BYTE_W-1:0]  o_byte;
  logic               o_last;
  logic               o_done;

  logic               adv;
  logic               is_last;
  logic               in_data;
  logic               load;
  logic [CW-1:0]      hdr_end_next;
  logic [CW-1:0]      data_end_next;
  logic [CW-1:0]      last_idx_next;

  // Step when the output register is free or being drained
  assign adv       = busy && (!o_valid || sector.ready);
  assign is_last   = (idx == last_idx);
  assign in_data   = (idx >= hdr_end) && (idx < data_end);
  assign grp_ready = !busy || (adv && is_last);
  assign load      = grp_valid && grp_ready;

  // Run layout of the incoming group
  always_comb begin
    hdr_end_next  = grp.header ? CW'(HEADER_BYTES) : '0;
    data_end_next = hdr_end_next + (grp.eight_bytes ? CW'(GROUP_BYTES) : CW'(SHORT_RUN));
    last_idx_next = data_end_next + (grp.sector_end ? CW'(PAD) : '0) - CW'(1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (adv) o_valid <= 1'b1;
      else if (sector.ready) o_valid <= 1'b0;
      if (load) busy <= 1'b1;
      else if (adv && is_last) busy <= 1'b0;
    end
  end

  // Payload and run position
  always_ff @(posedge clk) begin
    if (adv) begin
      o_byte <= in_data ? data[GROUP_W-1 -: BYTE_W] : '0;
      o_last <= is_last;
      o_done <= is_last && sect_end;
      idx    <= idx + CW'(1);
      if (in_data) data <= data << BYTE_W;
    end
    if (load) begin
      idx      <= '0;
      data     <= grp.data;
      hdr_end  <= hdr_end_next;
      data_end <= data_end_next;
      last_idx <= last_idx_next;
      sect_end <= grp.sector_end;
    end
  end

  assign sector.valid       = o_valid;
  assign sector.out_byte    = o_byte;
  assign sector.run_last    = o_last;
  assign sector.sector_done = o_done;

endmodule

// ===== sv/sector_60bit_word_repacker.sv =====
// Top level: 64-bit byte groups repacked into sectors of packed 60-bit words.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+-------------------
//   image    | in  | in_byte[7:0]                     | valid / ready
//   sector   | out | out_byte[7:0], run_last, sect..  | valid / ready
//   cfg      | in  | cfg_wr_data (byte order)         | cfg_wr_en, no wait
//
// One input byte per cycle when ready; every eighth byte completes a group,
// emitted at one byte per cycle unless output stalls: 7 or 8 bytes, plus 3
// header bytes on a sector's first group and the padding run on its last. The
// serializer's output run sets the rate; input stalls only while a completed
// group waits for it. Groups pass the group and serializer data registers to the
// output register. Reset has no clearing pass; output stalls hold that register.
module sector_60bit_word_repacker import s60r_pkg::*; #(
  parameter int GROUPS_PER_SECTOR = DEF_GROUPS_PER_SECTOR,
  parameter int OUT_SECTOR_BYTES  = DEF_OUT_SECTOR_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  s60r_in_if.sink     image,
  s60r_out_if.source  sector
);

  grp_t grp;
  logic grp_valid;
  logic grp_ready;

  // Byte gathering, ordering and nibble carry
  s60r_gather #(
    .GROUPS_PER_SECTOR (GROUPS_PER_SECTOR)
  ) u_gather (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .image       (image),
    .grp         (grp),
    .grp_valid   (grp_valid),
    .grp_ready   (grp_ready)
  );

  // Byte run output with header and padding
  s60r_serial #(
    .GROUPS_PER_SECTOR (GROUPS_PER_SECTOR),
    .OUT_SECTOR_BYTES  (OUT_SECTOR_BYTES)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .sector    (sector)
  );

endmodule

// ===== sv/s60r_checker.sv =====
// Checker: port-level assertions for the repacker, bound to the top level.
module s60r_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       sector_done
);

  logic out_acc;
  logic after_done;

  assign out_acc = valid && ready;

  // Tracks that the previous output transaction closed a sector
  always_ff @(posedge clk) begin
    if (rst) after_done <= 1'b0;
    else if (out_acc) after_done <= sector_done;
  end

  // Output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("output valid after reset");

  // A sector always closes on the last byte of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && sector_done |-> run_last)
    else $error("sector_done without run_last");

  // A new sector opens with a zero header byte
  a_header_zero: assert property (@(posedge clk) disable iff (rst)
    out_acc && after_done |-> out_byte == 8'd0)
    else $error("sector does not start with a zero header byte");

  // Stalled output transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_byte) &&
      $stable(run_last) && $stable(sector_done))
    else $error("stalled output transaction changed");

endmodule

bind sector_60bit_word_repacker s60r_checker u_s60r_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (sector.valid),
  .ready       (sector.ready),
  .out_byte    (sector.out_byte),
  .run_last    (sector.run_last),
  .sector_done (sector.sector_done)
);

// ===== bench/tb_sector_60bit_word_repacker.sv =====
// 60-bit sector repacker testbench: directed and random paced traffic checked by a byte-level predictor.
module tb_sector_60bit_word_repacker;
  import s60r_pkg::*;

  localparam int SECTOR_GROUPS = DEF_GROUPS_PER_SECTOR;
  localparam int SECTOR_BYTES  = DEF_OUT_SECTOR_BYTES;
  localparam int RANDOM_BYTES  = 286;
  localparam int PIPE_SETTLE   = 4;

  // One expected output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       sector_done;
  } sector_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data = 8'h00;
  logic out_ready = 1'b0;

  s60r_in_if  image_ch ();
  s60r_out_if sector_ch ();

  assign image_ch.valid   = in_valid;
  assign image_ch.in_byte = in_data;
  assign sector_ch.ready  = out_ready;

  sector_60bit_word_repacker #(
    .GROUPS_PER_SECTOR(SECTOR_GROUPS),
    .OUT_SECTOR_BYTES(SECTOR_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .image(image_ch.sink),
    .sector(sector_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirrors the block after reset
  logic [63:0] grp_data = '0;
  logic [2:0]  grp_pos = '0;
  int          grp_count = 0;
  logic [3:0]  carry_nib = '0;
  logic        carry_held = 1'b0;
  logic        byte_order = 1'b1;

  sector_byte_t sector_bytes_due [$];
  logic [7:0]   image_bytes_pending [$];

  int   bytes_queued = 0;
  int   bytes_taken = 0;
  int   error_count = 0;
  logic tx_paced = 1'b0;
  logic rx_stall = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  logic [15:0] rx_pat = 16'hFFFF;
  int   rx_tick = 0;
  sector_byte_t got_due;

  // Absorb one image byte; a completed group queues its packed output bytes
  function automatic void repack_byte(input logic [7:0] b);
    logic [63:0] t;
    logic [59:0] w;
    logic [63:0] v;
    logic [7:0]  run [$];
    logic        sect_end;
    int          used;
    int          i;
    sector_byte_t r;
    grp_data[8*grp_pos +: 8] = b;
    if (grp_pos != 3'd7) begin
      grp_pos = grp_pos + 3'd1;
      return;
    end
    grp_pos = 3'd0;
    t = '0;
    // byte order is taken at the eighth byte for the whole group
    for (i = 0; i < GROUP_BYTES; i++) begin
      if (byte_order) t[8*i +: 8] = grp_data[8*i +: 8];
      else t[8*i +: 8] = grp_data[8*(7-i) +: 8];
    end
    w = t[59:0];
    if (grp_count == 0) begin
      for (i = 0; i < HEADER_BYTES; i++) run.push_back(8'h00);
    end
    if (carry_held) begin
      v = {carry_nib, w};
      for (i = 0; i < 8; i++) run.push_back(v[56-8*i +: 8]);
      carry_held = 1'b0;
      carry_nib = 4'h0;
    end else begin
      for (i = 0; i < 7; i++) run.push_back(w[52-8*i +: 8]);
      carry_nib = w[3:0];
      carry_held = 1'b1;
    end
    sect_end = (grp_count + 1 >= SECTOR_GROUPS);
    if (sect_end) begin
      // odd group count: flush the pending nibble
      if (carry_held) begin
        run.push_back({carry_nib, 4'h0});
        carry_held = 1'b0;
        carry_nib = 4'h0;
      end
      used = HEADER_BYTES + (SECTOR_GROUPS * WORD_BITS + 7) / 8;
      while (used < SECTOR_BYTES) begin
        run.push_back(8'h00);
        used++;
      end
      grp_count = 0;
    end else begin
      grp_count = grp_count + 1;
    end
    for (i = 0; i < run.size(); i++) begin
      r.data = run[i];
      r.run_last = (i == run.size() - 1);
      r.sector_done = sect_end && (i == run.size() - 1);
      sector_bytes_due.push_back(r);
    end
  endfunction

  // Input driver: bursts with random gaps when paced
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || image_ch.ready) begin
      if (in_valid) begin
        repack_byte(in_data);
        bytes_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (image_bytes_pending.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= image_bytes_pending.pop_front();
        if (tx_paced) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_tick = 0;
    end else begin
      if (sector_ch.valid && sector_ch.ready) begin
        if (sector_bytes_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction, expected none, got out_byte %h", $time,
                   sector_ch.out_byte);
        end else begin
          got_due = sector_bytes_due.pop_front();
          if (sector_ch.out_byte !== got_due.data) begin
            error_count++;
            $display("%0t: out_byte expected %h got %h", $time, got_due.data,
                     sector_ch.out_byte);
          end
          if (sector_ch.run_last !== got_due.run_last) begin
            error_count++;
            $display("%0t: run_last expected %b got %b", $time, got_due.run_last,
                     sector_ch.run_last);
          end
          if (sector_ch.sector_done !== got_due.sector_done) begin
            error_count++;
            $display("%0t: sector_done expected %b got %b", $time, got_due.sector_done,
                     sector_ch.sector_done);
          end
        end
      end
      rx_tick++;
      if (rx_tick % 64 == 0) rx_pat = 16'($urandom()) | 16'h1;
      out_ready <= !rx_stall || rx_pat[rx_tick[3:0]];
    end
  end

  // Block is idle once every byte is taken and every output has arrived
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || sector_bytes_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_byte_order(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    byte_order = v;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    image_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  initial begin : stimulus
    int n;
    int random_sent;
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes under the reset byte order, then a full pattern group
    tx_paced = 1'b0;
    rx_stall = 1'b0;
    for (i = 0; i < 4; i++) queue_byte(8'hFF);
    for (i = 0; i < 4; i++) queue_byte(8'h00);
    for (i = 0; i < 8; i++) queue_byte(8'h01 + 8'h22 * i[7:0]);
    wait_idle();
    // Order flipped mid-group: half a group under each order
    write_byte_order(1'b0);
    queue_byte(8'h5A);
    queue_byte(8'hA5);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    wait_idle();
    write_byte_order(1'b1);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'hFE);
    queue_byte(8'h80);
    wait_idle();

    // Random phases, each with its own byte order and pacing
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      write_byte_order(1'($urandom_range(0, 1)));
      tx_paced = ($urandom_range(0, 3) != 0);
      rx_stall = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 160);
      if (n > RANDOM_BYTES - random_sent) n = RANDOM_BYTES - random_sent;
      for (i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
      random_sent += n;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && sector_bytes_due.size() == 0) begin
      $display("tb_sector_60bit_word_repacker: clean");
    end else begin
      $display("tb_sector_60bit_word_repacker: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("tb_sector_60bit_word_repacker: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/s60r_pkg.sv
sv/s60r_in_if.sv
sv/s60r_out_if.sv
sv/s60r_gather.sv
sv/s60r_serial.sv
sv/sector_60bit_word_repacker.sv
sv/s60r_checker.sv
bench/tb_sector_60bit_word_repacker.sv
